// ===== rtl/core/alg_pkg.sv =====
// ---------------------------------------------------------------------------
// alg_pkg: shared types and constants for the associated Legendre evaluator
// Widths, fixed-point constants, unit control structs and the reciprocal table.
// ---------------------------------------------------------------------------
`default_nettype none

package alg_pkg;

    localparam int DEG_W   = 4;     // degree / order field width
    localparam int X_W     = 32;    // x in Q1.30
    localparam int VAL_W   = 64;    // P values in Q.24
    localparam int FAC_W   = 37;    // signed multiplier B operand
    localparam int MAGB_W  = 36;    // magnitude of B operand
    localparam int DIG_W   = 16;    // A digit per multiply step
    localparam int ACC_W   = VAL_W + MAGB_W;
    localparam int RAD_W   = 61;    // radicand 2^60 - x^2
    localparam int ROOT_W  = 31;    // sqrt result, Q.30
    localparam int SMALL_W = 5;     // small integer factors, up to 31

    localparam int DEFAULT_MAX_DEGREE = 12;

    localparam logic signed [X_W-1:0]   ONE_Q30 = 32'sd1073741824;
    localparam logic signed [X_W-1:0]   NEG_ONE_Q30 = -32'sd1073741824;
    localparam logic signed [VAL_W-1:0] ONE_Q24 = 64'sd16777216;
    localparam logic [RAD_W-1:0]        ONE_Q60 = RAD_W'(1) << 60;

    typedef struct packed {
        logic start;
        logic round30;      // 1: divide by 2^30 with rounding, 0: plain product
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } mul_sts_t;

    // round(2^30 / k) for k = 1..12
    function automatic logic [FAC_W-1:0] recip_q30(input logic [DEG_W-1:0] k);
        logic [FAC_W-1:0] r;
        case (k)
            4'd1:    r = 37'd1073741824;
            4'd2:    r = 37'd536870912;
            4'd3:    r = 37'd357913941;
            4'd4:    r = 37'd268435456;
            4'd5:    r = 37'd214748365;
            4'd6:    r = 37'd178956971;
            4'd7:    r = 37'd153391689;
            4'd8:    r = 37'd134217728;
            4'd9:    r = 37'd119304647;
            4'd10:   r = 37'd107374182;
            4'd11:   r = 37'd97612893;
            4'd0:    r = 37'd0;
            default: r = 37'd89478485;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/alg_if.sv =====
// ---------------------------------------------------------------------------
// alg_if: valid/ready channels of the Legendre evaluator
// Input word carries degree, order and x; output word carries the value.
// ---------------------------------------------------------------------------
`default_nettype none

interface alg_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [alg_pkg::DEG_W-1:0]               degree;
    logic [alg_pkg::DEG_W-1:0]               order;
    logic signed [alg_pkg::X_W-1:0]          x_value;

    modport source (output valid, degree, order, x_value, input ready);
    modport sink   (input valid, degree, order, x_value, output ready);
endinterface

interface alg_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [alg_pkg::VAL_W-1:0]        value;
    logic                                    saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/associated_legendre_eval.sv =====
// ---------------------------------------------------------------------------
// associated_legendre_eval: P_l^m(x) evaluator, fixed point
// Sequencer around one shared multiply unit and a bitwise root unit.
// ---------------------------------------------------------------------------
// Takes one word (degree l, order m, x in Q1.30) and returns P_l^m(x) with
// the (-1)^m phase in signed Q39.24, saturating and flagging any clipped
// step. x is clamped to +-1.0 first. Order above degree, or either above
// MAX_DEGREE, gives 0 right away (the word goes straight to the done state
// and then to the output register). Otherwise x^2 runs on the shared
// multiply unit, the root on the root unit, then m products for P_m^m,
// one for P_{m+1}^m and three per recurrence step, all on the multiply
// unit. With order 0 the x^2 and root phases are skipped. The block takes
// one word at a time; a new word is accepted while the previous result
// still waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module associated_legendre_eval #(
    parameter int MAX_DEGREE = alg_pkg::DEFAULT_MAX_DEGREE
) (
    input  wire        clk,
    input  wire        rst_n,
    alg_in_if.sink     in_ch,
    alg_out_if.source  out_ch
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ     = 4'd1;
    localparam logic [3:0] ST_ROOT   = 4'd2;
    localparam logic [3:0] ST_MM_FAC = 4'd3;
    localparam logic [3:0] ST_MM_MUL = 4'd4;
    localparam logic [3:0] ST_P1_FAC = 4'd5;
    localparam logic [3:0] ST_P1_MUL = 4'd6;
    localparam logic [3:0] ST_RA_FAC = 4'd7;
    localparam logic [3:0] ST_RA_MUL = 4'd8;
    localparam logic [3:0] ST_RB_MUL = 4'd9;
    localparam logic [3:0] ST_RR_MUL = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    localparam int DW = alg_pkg::DEG_W;
    localparam int VW = alg_pkg::VAL_W;
    localparam int FW = alg_pkg::FAC_W;
    localparam int SW = alg_pkg::SMALL_W;

    logic [3:0]               state_reg;
    logic [DW-1:0]            l_reg;
    logic [DW-1:0]            m_reg;
    logic [DW-1:0]            i_reg;        // P_m^m product counter
    logic [DW-1:0]            ll_reg;       // recurrence degree
    logic [SW-1:0]            fact_reg;     // odd factor 2i-1
    logic signed [31:0]       x_reg;
    logic [alg_pkg::ROOT_W-1:0] s_reg;
    logic signed [VW-1:0]     pmm_reg;
    logic signed [VW-1:0]     pn1_reg;
    logic signed [VW-1:0]     pll_reg;
    logic signed [VW-1:0]     a_reg;
    logic                     sat_reg;

    // shared multiply operands
    logic signed [VW-1:0]     op_a_reg;
    logic signed [FW-1:0]     op_b_reg;
    logic                     mul_start_reg;
    logic                     mul_rnd_reg;
    logic                     sqrt_start_reg;
    logic [alg_pkg::RAD_W-1:0] rad_reg;

    // output word
    logic                     out_valid_reg;
    logic signed [VW-1:0]     out_value_reg;
    logic                     out_sat_reg;

    alg_pkg::mul_req_t        mul_req;
    alg_pkg::mul_sts_t        mul_sts;
    logic signed [VW-1:0]     mul_res;
    logic                     sqrt_done;
    logic [alg_pkg::ROOT_W-1:0] sqrt_root;

    logic signed [31:0]       x_clamp;
    logic                     bad_item;
    logic [35:0]              fs_prod;
    logic signed [37:0]       xk_prod;
    logic [SW-1:0]            xk_fac;
    logic signed [VW:0]       diff;
    logic                     diff_ovf;
    logic signed [VW-1:0]     diff_sat;
    logic                     load_out;

    assign x_clamp  = (in_ch.x_value > alg_pkg::ONE_Q30) ? alg_pkg::ONE_Q30 :
                      (in_ch.x_value < alg_pkg::NEG_ONE_Q30) ? alg_pkg::NEG_ONE_Q30 :
                      in_ch.x_value;
    assign bad_item = (32'(in_ch.degree) > 32'(MAX_DEGREE))
                   || (32'(in_ch.order) > 32'(MAX_DEGREE))
                   || (in_ch.order > in_ch.degree);

    // small factor products, registered into the B operand
    assign fs_prod = 36'(fact_reg) * 36'(s_reg);
    assign xk_fac  = (state_reg == ST_P1_FAC) ? (SW'({m_reg, 1'b0}) + SW'(1))
                                              : (SW'({ll_reg, 1'b0}) - SW'(1));
    assign xk_prod = 38'(x_reg) * $signed({33'd0, xk_fac});

    // P_{ll-1} term minus P_{ll-2} term, saturating
    assign diff     = {a_reg[VW-1], a_reg} - {mul_res[VW-1], mul_res};
    assign diff_ovf = diff[VW] != diff[VW-1];
    assign diff_sat = diff_ovf ? (diff[VW] ? (64'sh1 << 63) : ~(64'sh1 << 63))
                               : diff[VW-1:0];

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    assign mul_req.start   = mul_start_reg;
    assign mul_req.round30 = mul_rnd_reg;

    alg_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .op_a   (op_a_reg),
        .op_b   (op_b_reg),
        .sts    (mul_sts),
        .result (mul_res)
    );

    alg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (rad_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= pll_reg;
                out_sat_reg   <= sat_reg;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        l_reg   <= in_ch.degree;
                        m_reg   <= in_ch.order;
                        x_reg   <= x_clamp;
                        sat_reg <= 1'b0;
                        pmm_reg <= alg_pkg::ONE_Q24;
                        if (bad_item)
                        begin
                            pll_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else if (in_ch.order == '0)
                            state_reg <= ST_P1_FAC;
                        else
                        begin
                            // x^2 on the shared unit, exact
                            op_a_reg      <= VW'(x_clamp);
                            op_b_reg      <= FW'(x_clamp);
                            mul_rnd_reg   <= 1'b0;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    if (mul_sts.done)
                    begin
                        rad_reg        <= alg_pkg::ONE_Q60 - mul_res[alg_pkg::RAD_W-1:0];
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (sqrt_done)
                    begin
                        s_reg     <= sqrt_root;
                        i_reg     <= DW'(1);
                        fact_reg  <= SW'(1);
                        state_reg <= ST_MM_FAC;
                    end
                end
                ST_MM_FAC:
                begin
                    // P_m^m *= -(2i-1) s
                    op_a_reg      <= pmm_reg;
                    op_b_reg      <= -$signed({1'b0, fs_prod});
                    mul_rnd_reg   <= 1'b1;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MM_MUL;
                end
                ST_MM_MUL:
                begin
                    if (mul_sts.done)
                    begin
                        pmm_reg <= mul_res;
                        sat_reg <= sat_reg | mul_sts.sat;
                        if (i_reg == m_reg)
                            state_reg <= ST_P1_FAC;
                        else
                        begin
                            i_reg     <= i_reg + DW'(1);
                            fact_reg  <= fact_reg + SW'(2);
                            state_reg <= ST_MM_FAC;
                        end
                    end
                end
                ST_P1_FAC:
                begin
                    if (l_reg == m_reg)
                    begin
                        pll_reg   <= pmm_reg;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        // P_{m+1}^m = x (2m+1) P_m^m
                        op_a_reg      <= pmm_reg;
                        op_b_reg      <= xk_prod[FW-1:0];
                        mul_rnd_reg   <= 1'b1;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P1_MUL;
                    end
                end
                ST_P1_MUL:
                begin
                    if (mul_sts.done)
                    begin
                        pn1_reg <= mul_res;
                        pll_reg <= mul_res;
                        sat_reg <= sat_reg | mul_sts.sat;
                        ll_reg  <= m_reg + DW'(2);
                        if ((m_reg + DW'(1)) == l_reg)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_RA_FAC;
                    end
                end
                ST_RA_FAC:
                begin
                    op_a_reg      <= pn1_reg;
                    op_b_reg      <= xk_prod[FW-1:0];
                    mul_rnd_reg   <= 1'b1;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_RA_MUL;
                end
                ST_RA_MUL:
                begin
                    if (mul_sts.done)
                    begin
                        // (ll+m-1) P_{ll-2}, exact integer product
                        a_reg         <= mul_res;
                        sat_reg       <= sat_reg | mul_sts.sat;
                        op_a_reg      <= pmm_reg;
                        op_b_reg      <= FW'(ll_reg) + FW'(m_reg) - FW'(1);
                        mul_rnd_reg   <= 1'b0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RB_MUL;
                    end
                end
                ST_RB_MUL:
                begin
                    if (mul_sts.done)
                    begin
                        // difference times recip(ll-m)
                        sat_reg       <= sat_reg | mul_sts.sat | diff_ovf;
                        op_a_reg      <= diff_sat;
                        op_b_reg      <= alg_pkg::recip_q30(ll_reg - m_reg);
                        mul_rnd_reg   <= 1'b1;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RR_MUL;
                    end
                end
                ST_RR_MUL:
                begin
                    if (mul_sts.done)
                    begin
                        pll_reg <= mul_res;
                        pmm_reg <= pn1_reg;
                        pn1_reg <= mul_res;
                        sat_reg <= sat_reg | mul_sts.sat;
                        ll_reg  <= ll_reg + DW'(1);
                        if (ll_reg == l_reg)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_RA_FAC;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value     = out_value_reg;
    assign out_ch.saturated = out_sat_reg;

    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mul_sts.busy)
        else $error("multiply unit busy while idle");
    a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_ROOT))
        else $error("root finished outside root phase");
    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.done |-> (state_reg == ST_SQ || state_reg == ST_MM_MUL
                          || state_reg == ST_P1_MUL || state_reg == ST_RA_MUL
                          || state_reg == ST_RB_MUL || state_reg == ST_RR_MUL))
        else $error("multiply result with no waiting phase");
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !load_out) |=> !out_ch.valid)
        else $error("output word repeated");

endmodule

`default_nettype wire

// ===== rtl/core/alg_mul.sv =====
// ---------------------------------------------------------------------------
// alg_mul: shared multi-cycle multiply, round and saturate unit
// 64b x 37b signed product over four 16-bit digit steps, then rounding.
// ---------------------------------------------------------------------------
`default_nettype none

module alg_mul (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire  alg_pkg::mul_req_t               req,
    input  wire  logic signed [alg_pkg::VAL_W-1:0] op_a,
    input  wire  logic signed [alg_pkg::FAC_W-1:0] op_b,
    output alg_pkg::mul_sts_t                     sts,
    output logic signed [alg_pkg::VAL_W-1:0]      result
);

    localparam int STEPS = alg_pkg::VAL_W / alg_pkg::DIG_W;

    logic [alg_pkg::VAL_W-1:0]  ua_reg;
    logic [alg_pkg::MAGB_W-1:0] ub_reg;
    logic [alg_pkg::ACC_W-1:0]  acc_reg;
    logic                       neg_reg;
    logic                       rnd_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       sat_reg;
    logic [2:0]                 step_reg;

    logic [alg_pkg::VAL_W-1:0]  ua_in;
    logic [alg_pkg::FAC_W-1:0]  ub_in;
    logic [alg_pkg::ACC_W-1:0]  partial;
    logic [alg_pkg::ACC_W-1:0]  rsum;
    logic [alg_pkg::ACC_W-1:0]  quot;
    logic [alg_pkg::VAL_W-1:0]  limit;
    logic                       over;

    assign ua_in   = op_a[alg_pkg::VAL_W-1] ? (~op_a + 1'b1) : op_a;
    assign ub_in   = op_b[alg_pkg::FAC_W-1] ? (~op_b + 1'b1) : op_b;
    assign partial = alg_pkg::ACC_W'(ua_reg[alg_pkg::VAL_W-1 -: alg_pkg::DIG_W])
                   * alg_pkg::ACC_W'(ub_reg);
    assign rsum    = acc_reg + (rnd_reg ? (alg_pkg::ACC_W'(1) << 29) : '0);
    assign quot    = rnd_reg ? (rsum >> 30) : rsum;
    assign limit   = neg_reg ? (64'h1 << 63) : ~(64'h1 << 63);
    assign over    = (|quot[alg_pkg::ACC_W-1:alg_pkg::VAL_W])
                   || (quot[alg_pkg::VAL_W-1:0] > limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                ua_reg   <= ua_in;
                ub_reg   <= ub_in[alg_pkg::MAGB_W-1:0];
                neg_reg  <= op_a[alg_pkg::VAL_W-1] ^ op_b[alg_pkg::FAC_W-1];
                rnd_reg  <= req.round30;
                acc_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'(STEPS))
                begin
                    // round / saturate
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    sat_reg  <= over;
                    if (over)
                        result <= neg_reg ? (64'sh1 << 63) : ~(64'sh1 << 63);
                    else
                        result <= neg_reg ? (~quot[alg_pkg::VAL_W-1:0] + 1'b1)
                                          : quot[alg_pkg::VAL_W-1:0];
                end
                else
                begin
                    acc_reg  <= (acc_reg << alg_pkg::DIG_W) + partial;
                    ua_reg   <= ua_reg << alg_pkg::DIG_W;
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.sat  = sat_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiply started while busy");
    a_done_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished multiply");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= 3'(STEPS))
        else $error("multiply step count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/alg_sqrt.sv =====
// ---------------------------------------------------------------------------
// alg_sqrt: bitwise integer square root of a 61-bit radicand
// One result bit per cycle, for a 31-bit root.
// ---------------------------------------------------------------------------
`default_nettype none

module alg_sqrt (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  wire  logic [alg_pkg::RAD_W-1:0]    radicand,
    output logic                               done,
    output logic [alg_pkg::ROOT_W-1:0]         root
);

    logic [alg_pkg::RAD_W-1:0] rem_reg;
    logic [alg_pkg::RAD_W-1:0] res_reg;
    logic [alg_pkg::RAD_W-1:0] bit_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [alg_pkg::RAD_W-1:0] trial;
    logic                      take;
    logic [alg_pkg::RAD_W-1:0] res_step;

    assign trial    = res_reg + bit_reg;
    assign take     = rem_reg >= trial;
    assign res_step = take ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= radicand;
                res_reg  <= '0;
                bit_reg  <= alg_pkg::ONE_Q60;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (take)
                    rem_reg <= rem_reg - trial;
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[alg_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire
